>>> rtl/tcw_pkg.sv
package tcw_pkg;

    // field widths
    localparam int WIN_W  = 32;
    localparam int MSS_W  = 16;
    localparam int SEG_W  = 4;
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 1;

    // event codes
    localparam logic [REQ_W-1:0] EV_ACK     = 2'd0;
    localparam logic [REQ_W-1:0] EV_TIMEOUT = 2'd1;
    localparam logic [REQ_W-1:0] EV_INIT    = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MSS  = 1'd0;
    localparam logic [IDX_W-1:0] REG_SEGS = 1'd1;

    localparam logic [MSS_W-1:0] RESET_MSS  = 16'd1460;
    localparam logic [SEG_W-1:0] RESET_SEGS = 4'd4;
    localparam logic [WIN_W-1:0] ALL_ONES   = {WIN_W{1'b1}};
    localparam logic [WIN_W-1:0] RESET_CWND = WIN_W'(RESET_MSS * RESET_SEGS);

    // saturating 32-bit add
    function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
        logic [WIN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIN_W] ? ALL_ONES : s[WIN_W-1:0];
    endfunction

endpackage

>>> rtl/tcw_muldiv.sv
// Bit-serial a*b/d: shift-add multiply (one multiplier bit per cycle), then
// restoring divide (one quotient bit per cycle). Requires a*b < d * 2^MSS_W,
// which holds when a <= d, so the quotient fits MSS_W bits.
module tcw_muldiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tcw_pkg::WIN_W-1:0]  multiplicand,
    input  logic [tcw_pkg::MSS_W-1:0]  multiplier,
    input  logic [tcw_pkg::WIN_W-1:0]  divisor,
    output logic                       done,
    output logic [tcw_pkg::MSS_W-1:0]  quotient
);
    import tcw_pkg::*;

    localparam int CNT_W  = $clog2(MSS_W);
    localparam int PROD_W = WIN_W + MSS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [WIN_W-1:0]    mcand_reg, mcand_next;
    logic [WIN_W-1:0]    div_reg, div_next;

    logic [WIN_W:0]      mul_sum;
    logic [WIN_W:0]      trial;
    logic                q_bit;
    logic                last_step;

    // partial-product add on the high half
    assign mul_sum   = {1'b0, prod_reg[PROD_W-1:MSS_W]}
                     + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    // next remainder candidate with the next dividend bit
    assign trial     = {prod_reg[PROD_W-1:MSS_W], prod_reg[MSS_W-1]};
    assign q_bit     = (trial >= {1'b0, div_reg});
    assign last_step = (cnt_reg == CNT_W'(MSS_W - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    prod_next  = {{WIN_W{1'b0}}, multiplier};
                    mcand_next = multiplicand;
                    div_next   = divisor;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[MSS_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (q_bit)
                begin
                    prod_next[PROD_W-1:MSS_W] = WIN_W'(trial - {1'b0, div_reg});
                end
                else
                begin
                    prod_next[PROD_W-1:MSS_W] = trial[WIN_W-1:0];
                end
                prod_next[MSS_W-1:0] = {prod_reg[MSS_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
    end

    assign done     = done_reg;
    assign quotient = prod_reg[MSS_W-1:0];

endmodule

>>> rtl/tcp_congestion_window.sv
// Timing: init, timeout and unknown events and slow-start or zero-window acks give
//   their result the cycle after the transfer; other avoidance acks use the serial unit.
// Throughput: one event per cycle while the output is taken, except avoidance acks,
//   which hold off new events until the bit-serial multiply and divide unit is done.
// Reset: window = 1460 * 4, threshold all ones, loss flag clear, mss 1460,
//   initial segments 4; no result pending.
module tcp_congestion_window (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration writes
    input  logic                       cfg_we,
    input  logic [tcw_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::MSS_W-1:0]  cfg_data,
    // event channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tcw_pkg::REQ_W-1:0]  req_type,
    input  logic [tcw_pkg::WIN_W-1:0]  acked_bytes,
    input  logic [tcw_pkg::WIN_W-1:0]  bytes_in_flight,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tcw_pkg::WIN_W-1:0]  window,
    output logic [tcw_pkg::WIN_W-1:0]  threshold,
    output logic                       in_loss
);
    import tcw_pkg::*;

    // configuration registers
    logic [MSS_W-1:0]  mss_reg;
    logic [SEG_W-1:0]  segs_reg;

    // connection state
    logic [WIN_W-1:0]  cwnd_reg, cwnd_next;
    logic [WIN_W-1:0]  ssthresh_reg, ssthresh_next;
    logic              loss_reg, loss_next;

    // busy while the serial unit works on an avoidance ack
    logic              busy_reg, busy_next;

    // output holding register
    logic              out_valid_reg, out_valid_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [WIN_W-1:0]  threshold_reg, threshold_next;
    logic              in_loss_reg, in_loss_next;

    logic              in_xfer;
    logic              slow_start;

    // ack terms
    logic [WIN_W-1:0]  ack_eff;
    logic [WIN_W-1:0]  ss_inc;

    // timeout terms
    logic [WIN_W-1:0]  fl_eff;
    logic [WIN_W-1:0]  fl_half;
    logic [WIN_W-1:0]  two_mss;
    logic [WIN_W-1:0]  to_thresh;

    logic              unit_start;
    logic              unit_done;
    logic [MSS_W-1:0]  unit_quot;
    logic [WIN_W-1:0]  ca_inc;

    // one event in flight; the output register must be free or draining
    assign in_ready   = !busy_reg && (!out_valid_reg || out_ready);
    assign in_xfer    = in_valid && in_ready;
    assign slow_start = (cwnd_reg < ssthresh_reg);

    assign ack_eff = (acked_bytes < cwnd_reg) ? acked_bytes : cwnd_reg;
    assign ss_inc  = (acked_bytes < {{(WIN_W-MSS_W){1'b0}}, mss_reg})
                   ? acked_bytes : {{(WIN_W-MSS_W){1'b0}}, mss_reg};

    assign fl_eff  = (bytes_in_flight < cwnd_reg) ? bytes_in_flight : cwnd_reg;
    assign fl_half = {1'b0, fl_eff[WIN_W-1:1]};
    assign two_mss = {{(WIN_W-MSS_W-1){1'b0}}, mss_reg, 1'b0};

    always_comb
    begin
        to_thresh = (fl_half > two_mss) ? fl_half : two_mss;
        // in loss the threshold never rises
        if (loss_reg && (to_thresh > ssthresh_reg))
        begin
            to_thresh = ssthresh_reg;
        end
    end

    // avoidance increment is at least one byte
    assign ca_inc = (unit_quot == '0) ? WIN_W'(1)
                  : {{(WIN_W-MSS_W){1'b0}}, unit_quot};

    always_comb
    begin
        cwnd_next      = cwnd_reg;
        ssthresh_next  = ssthresh_reg;
        loss_next      = loss_reg;
        busy_next      = busy_reg;
        unit_start     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        window_next    = window_reg;
        threshold_next = threshold_reg;
        in_loss_next   = in_loss_reg;

        if (in_xfer)
        begin
            unique case (req_type)
                EV_ACK:
                begin
                    loss_next = 1'b0;
                    if (slow_start)
                    begin
                        cwnd_next = sat_add(cwnd_reg, ss_inc);
                    end
                    else if (cwnd_reg == '0)
                    begin
                        // zero window: step by one, no division
                        cwnd_next = sat_add(cwnd_reg, WIN_W'(1));
                    end
                    else
                    begin
                        busy_next  = 1'b1;
                        unit_start = 1'b1;
                    end
                end
                EV_TIMEOUT:
                begin
                    ssthresh_next = to_thresh;
                    cwnd_next     = {{(WIN_W-MSS_W){1'b0}}, mss_reg};
                    loss_next     = 1'b1;
                end
                EV_INIT:
                begin
                    cwnd_next     = {{(WIN_W-MSS_W){1'b0}}, mss_reg}
                                  * {{(WIN_W-SEG_W){1'b0}}, segs_reg};
                    ssthresh_next = ALL_ONES;
                    loss_next     = 1'b0;
                end
                default:
                begin
                    // unknown event: report current state
                end
            endcase

            if (!unit_start)
            begin
                out_valid_next = 1'b1;
                window_next    = cwnd_next;
                threshold_next = ssthresh_next;
                in_loss_next   = loss_next;
            end
        end

        if (unit_done)
        begin
            cwnd_next      = sat_add(cwnd_reg, ca_inc);
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            window_next    = cwnd_next;
            threshold_next = ssthresh_reg;
            in_loss_next   = loss_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg       <= RESET_MSS;
            segs_reg      <= RESET_SEGS;
            cwnd_reg      <= RESET_CWND;
            ssthresh_reg  <= ALL_ONES;
            loss_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MSS:  mss_reg  <= cfg_data;
                    REG_SEGS: segs_reg <= cfg_data[SEG_W-1:0];
                    default:  ;
                endcase
            end
            cwnd_reg      <= cwnd_next;
            ssthresh_reg  <= ssthresh_next;
            loss_reg      <= loss_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg    <= window_next;
        threshold_reg <= threshold_next;
        in_loss_reg   <= in_loss_next;
    end

    // min(acked, cwnd) * mss / cwnd, one bit per cycle
    tcw_muldiv u_muldiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (unit_start),
        .multiplicand (ack_eff),
        .multiplier   (mss_reg),
        .divisor      (cwnd_reg),
        .done         (unit_done),
        .quotient     (unit_quot)
    );

    assign out_valid = out_valid_reg;
    assign window    = window_reg;
    assign threshold = threshold_reg;
    assign in_loss   = in_loss_reg;

endmodule
